// ===== hdl/sac_pkg.sv =====
// ----------------------------------------------------------------------------
// Sample statistics accumulator package
// Widths, request codes and shared types for the accumulator and its units.
// ----------------------------------------------------------------------------
package sac_pkg;

   localparam int SAMPLE_BITS = 10;
   localparam int COUNT_BITS  = 20;
   localparam int TIME_BITS   = 32;
   localparam int FRAC_BITS   = 8;

   localparam int MIN_BITS  = SAMPLE_BITS + 1;
   localparam int SUM_BITS  = SAMPLE_BITS + COUNT_BITS;
   localparam int SQ_BITS   = 2 * SAMPLE_BITS + COUNT_BITS;
   localparam int HALF_SQ   = SQ_BITS / 2;
   localparam int MEAN_BITS = SAMPLE_BITS + FRAC_BITS;
   localparam int VAR_BITS  = 2 * SAMPLE_BITS + 7;

   // Shared multiplier operand and product widths.
   localparam int MUL_BITS  = SUM_BITS;
   localparam int PROD_BITS = 2 * MUL_BITS;

   // n * sumsq numerator and n * (n - 1) denominator.
   localparam int NUM_BITS  = COUNT_BITS + SQ_BITS;
   localparam int DEN_BITS  = 2 * COUNT_BITS;

   // Divider: partial remainder as wide as the divisor, dividend tail bits.
   localparam int LOW_BITS  = VAR_BITS;
   localparam int STEP_BITS = $clog2(LOW_BITS + 1);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [MIN_BITS-1:0]   MIN_RESET = {1'b1, {SAMPLE_BITS{1'b0}}};

   typedef logic [1:0] req_code_type;
   localparam req_code_type REQ_SAMPLE = 2'd0;
   localparam req_code_type REQ_CLEAR  = 2'd1;
   localparam req_code_type REQ_BEGIN  = 2'd2;
   localparam req_code_type REQ_END    = 2'd3;

   typedef struct packed {
      logic                 start;
      logic [DEN_BITS-1:0]  rem_init;
      logic [LOW_BITS-1:0]  low_bits;
      logic [DEN_BITS-1:0]  divisor;
      logic [STEP_BITS-1:0] steps;
   } div_cmd_type;

   typedef struct packed {
      logic                busy;
      logic                done;
      logic [LOW_BITS-1:0] quotient;
   } div_sts_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] count;
      logic [MIN_BITS-1:0]   min_value;
      logic [SAMPLE_BITS-1:0] max_value;
      logic [MEAN_BITS-1:0]  mean_q8;
      logic [VAR_BITS-1:0]   variance_q8;
      logic [TIME_BITS-1:0]  start_time;
      logic [TIME_BITS-1:0]  end_time;
      logic                  saturated;
   } rsp_payload_type;

endpackage

// ===== hdl/sac_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel carrying one request beat: code, sample and time.
// ----------------------------------------------------------------------------
interface sac_req_if;
   import sac_pkg::*;

   logic                   valid;
   logic                   ready;
   req_code_type           req_type;
   logic [SAMPLE_BITS-1:0] sample;
   logic [TIME_BITS-1:0]   time_ms;

   modport source (output valid, output req_type, output sample, output time_ms,
                   input ready);
   modport sink   (input valid, input req_type, input sample, input time_ms,
                   output ready);
endinterface

// ===== hdl/sac_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel interface
// Valid/ready channel carrying one statistics report beat.
// ----------------------------------------------------------------------------
interface sac_rsp_if;
   import sac_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [COUNT_BITS-1:0]  count;
   logic [MIN_BITS-1:0]    min_value;
   logic [SAMPLE_BITS-1:0] max_value;
   logic [MEAN_BITS-1:0]   mean_q8;
   logic [VAR_BITS-1:0]    variance_q8;
   logic [TIME_BITS-1:0]   start_time;
   logic [TIME_BITS-1:0]   end_time;
   logic                   saturated;

   modport source (output valid, output count, output min_value, output max_value,
                   output mean_q8, output variance_q8, output start_time,
                   output end_time, output saturated, input ready);
   modport sink   (input valid, input count, input min_value, input max_value,
                   input mean_q8, input variance_q8, input start_time,
                   input end_time, input saturated, output ready);
endinterface

// ===== hdl/sac_mul.sv =====
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned multiplier with a registered product, one result per cycle.
// ----------------------------------------------------------------------------
module sac_mul (
   input  logic                          clock,
   input  logic [sac_pkg::MUL_BITS-1:0]  mul_a,
   input  logic [sac_pkg::MUL_BITS-1:0]  mul_b,
   output logic [sac_pkg::PROD_BITS-1:0] product
);
   import sac_pkg::*;

   logic [PROD_BITS-1:0] product_ff;
   logic [PROD_BITS-1:0] product_in;

   assign product_in = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;
endmodule

// ===== hdl/sac_div.sv =====
// ----------------------------------------------------------------------------
// Restoring divider
// Produces one quotient bit per cycle from a preloaded partial remainder.
// ----------------------------------------------------------------------------
module sac_div (
   input  logic                 clock,
   input  logic                 reset,
   input  sac_pkg::div_cmd_type cmd,
   output sac_pkg::div_sts_type sts
);
   import sac_pkg::*;

   logic [DEN_BITS-1:0]  rem_ff, rem_in;
   logic [LOW_BITS-1:0]  low_ff, low_in;
   logic [LOW_BITS-1:0]  quo_ff, quo_in;
   logic [DEN_BITS-1:0]  div_ff, div_in;
   logic [STEP_BITS-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [DEN_BITS:0] shifted;
   logic [DEN_BITS:0] trial;
   logic              take;

   // Bring down the next dividend bit and try a subtraction.
   assign shifted = {rem_ff, low_ff[LOW_BITS-1]};
   assign trial   = shifted - {1'b0, div_ff};
   assign take    = (shifted >= {1'b0, div_ff});

   always_comb begin
      rem_in  = rem_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         rem_in  = cmd.rem_init;
         low_in  = cmd.low_bits;
         quo_in  = '0;
         div_in  = cmd.divisor;
         cnt_in  = cmd.steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = take ? trial[DEN_BITS-1:0] : shifted[DEN_BITS-1:0];
         low_in = {low_ff[LOW_BITS-2:0], 1'b0};
         quo_in = {quo_ff[LOW_BITS-2:0], take};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign sts.busy     = busy_ff;
   assign sts.done     = done_ff;
   assign sts.quotient = quo_ff;
endmodule

// ===== hdl/sample_statistics_accumulator.sv =====
// ----------------------------------------------------------------------------
// Sample statistics accumulator
// Running count, minimum, maximum, mean and variance of converter samples.
// ----------------------------------------------------------------------------
// Every request beat on req_port is a sample, a clear, a window begin or a
// window end. Each request produces exactly one report beat on rsp_port with
// the statistics as they stand after that request: count, minimum, maximum,
// mean and sample variance with eight fraction bits, the window times and a
// saturation flag.
// The block takes one request at a time. A request runs through one shared
// 30x30 multiplier for five products (the sample square, two halves of
// n * sumsq, sum squared and n * (n - 1)), then one radix-2 divider for 18
// mean steps and 27 variance steps. A new request is not accepted until
// the report of the last one has been passed to the output register.
// The report sits in an output register, so a new request is accepted while
// an earlier report still waits; if the receiver stalls, the next report
// waits in the sequencer until the output register frees.
// Reset (synchronous, active high) clears every statistic to its empty value:
// count zero, minimum one above full scale, maximum zero, window times zero.
// ----------------------------------------------------------------------------
module sample_statistics_accumulator (
   input logic      clock,
   input logic      reset,
   sac_req_if.sink  req_port,
   sac_rsp_if.source rsp_port
);
   import sac_pkg::*;

   typedef enum logic [11:0] {
      ST_IDLE      = 12'b0000_0000_0001,
      ST_SQR       = 12'b0000_0000_0010,
      ST_ADD_SQ    = 12'b0000_0000_0100,
      ST_MUL_LO    = 12'b0000_0000_1000,
      ST_MUL_HI    = 12'b0000_0001_0000,
      ST_MUL_SQ    = 12'b0000_0010_0000,
      ST_MUL_DEN   = 12'b0000_0100_0000,
      ST_MEAN_GO   = 12'b0000_1000_0000,
      ST_MEAN_WAIT = 12'b0001_0000_0000,
      ST_VAR_GO    = 12'b0010_0000_0000,
      ST_VAR_WAIT  = 12'b0100_0000_0000,
      ST_FINISH    = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // Architectural statistics.
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [MIN_BITS-1:0]    min_ff, min_in;
   logic [SAMPLE_BITS-1:0] max_ff, max_in;
   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [SQ_BITS-1:0]     sumsq_ff, sumsq_in;
   logic [TIME_BITS-1:0]   start_ff, start_in;
   logic [TIME_BITS-1:0]   end_ff, end_in;
   logic                   sat_ff, sat_in;

   // Working registers for the derived values.
   logic [SAMPLE_BITS-1:0] smp_ff, smp_in;
   logic                   applied_ff, applied_in;
   logic [NUM_BITS-1:0]    acc_ff, acc_in;
   logic [NUM_BITS-1:0]    spread_ff, spread_in;
   logic                   neg_ff, neg_in;
   logic [DEN_BITS-1:0]    den_ff, den_in;
   logic [MEAN_BITS-1:0]   mean_ff, mean_in;
   logic [VAR_BITS-1:0]    var_ff, var_in;

   // Output register.
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic [MUL_BITS-1:0]  mul_a, mul_b;
   logic [PROD_BITS-1:0] product;
   logic [NUM_BITS:0]    diff;
   logic                 accept;
   logic                 out_free;
   div_cmd_type          div_cmd;
   div_sts_type          div_sts;

   sac_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (product)
   );

   sac_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .sts   (div_sts)
   );

   assign req_port.ready = (state_ff == ST_IDLE);
   assign accept         = req_port.valid && req_port.ready;
   assign out_free       = !rsp_valid_ff || rsp_port.ready;

   // n * sumsq minus sum squared, with the borrow telling a negative spread.
   assign diff = {1'b0, acc_ff} - {1'b0, product[NUM_BITS-1:0]};

   // Operands for the shared multiplier; the product appears one state later.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_SQR: begin
            mul_a = MUL_BITS'(smp_ff);
            mul_b = MUL_BITS'(smp_ff);
         end
         ST_MUL_LO: begin
            mul_a = MUL_BITS'(count_ff);
            mul_b = MUL_BITS'(sumsq_ff[HALF_SQ-1:0]);
         end
         ST_MUL_HI: begin
            mul_a = MUL_BITS'(count_ff);
            mul_b = MUL_BITS'(sumsq_ff[SQ_BITS-1:HALF_SQ]);
         end
         ST_MUL_SQ: begin
            mul_a = sum_ff;
            mul_b = sum_ff;
         end
         ST_MUL_DEN: begin
            mul_a = MUL_BITS'(count_ff);
            mul_b = MUL_BITS'(count_ff - 1'b1);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Divider commands: the mean divides sum * 256 by n, the variance divides
   // the spread * 256 by n * (n - 1). Only the quotient bits that can be set
   // are stepped, so the partial remainder starts from the upper dividend.
   always_comb begin
      div_cmd = '0;
      if (state_ff == ST_MEAN_GO) begin
         div_cmd.start    = 1'b1;
         div_cmd.rem_init = DEN_BITS'(sum_ff[SUM_BITS-1:SAMPLE_BITS]);
         div_cmd.low_bits = {sum_ff[SAMPLE_BITS-1:0], {(LOW_BITS - SAMPLE_BITS){1'b0}}};
         div_cmd.divisor  = DEN_BITS'(count_ff);
         div_cmd.steps    = STEP_BITS'(MEAN_BITS);
      end else if (state_ff == ST_VAR_GO) begin
         div_cmd.start    = 1'b1;
         div_cmd.rem_init = spread_ff[VAR_BITS-FRAC_BITS+DEN_BITS-1 -: DEN_BITS];
         div_cmd.low_bits = {spread_ff[VAR_BITS-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
         div_cmd.divisor  = den_ff;
         div_cmd.steps    = STEP_BITS'(VAR_BITS);
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      sum_in       = sum_ff;
      sumsq_in     = sumsq_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      sat_in       = sat_ff;
      smp_in       = smp_ff;
      applied_in   = applied_ff;
      acc_in       = acc_ff;
      spread_in    = spread_ff;
      neg_in       = neg_ff;
      den_in       = den_ff;
      mean_in      = mean_ff;
      var_in       = var_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_port.ready ? 1'b0 : rsp_valid_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in   = ST_SQR;
               smp_in     = req_port.sample;
               applied_in = 1'b0;
               case (req_port.req_type)
                  REQ_SAMPLE: begin
                     // A full counter drops the sample and flags it.
                     if (count_ff == COUNT_MAX) begin
                        sat_in = 1'b1;
                     end else begin
                        applied_in = 1'b1;
                        count_in   = count_ff + 1'b1;
                        if (MIN_BITS'(req_port.sample) < min_ff) begin
                           min_in = MIN_BITS'(req_port.sample);
                        end
                        if (req_port.sample > max_ff) begin
                           max_in = req_port.sample;
                        end
                        sum_in = sum_ff + SUM_BITS'(req_port.sample);
                     end
                  end
                  REQ_CLEAR: begin
                     count_in = '0;
                     min_in   = MIN_RESET;
                     max_in   = '0;
                     sum_in   = '0;
                     sumsq_in = '0;
                     start_in = '0;
                     end_in   = '0;
                     sat_in   = 1'b0;
                  end
                  REQ_BEGIN: begin
                     // Only an unset start time is taken.
                     if (start_ff == '0) begin
                        start_in = req_port.time_ms;
                     end
                  end
                  default: begin
                     end_in = req_port.time_ms;
                  end
               endcase
            end
         end
         ST_SQR: begin
            state_in = ST_ADD_SQ;
         end
         ST_ADD_SQ: begin
            if (applied_ff) begin
               sumsq_in = sumsq_ff + SQ_BITS'(product[2*SAMPLE_BITS-1:0]);
            end
            state_in = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            acc_in   = product[NUM_BITS-1:0];
            state_in = ST_MUL_SQ;
         end
         ST_MUL_SQ: begin
            acc_in   = acc_ff + {product[NUM_BITS-HALF_SQ-1:0], {HALF_SQ{1'b0}}};
            state_in = ST_MUL_DEN;
         end
         ST_MUL_DEN: begin
            spread_in = diff[NUM_BITS-1:0];
            neg_in    = diff[NUM_BITS];
            state_in  = ST_MEAN_GO;
         end
         ST_MEAN_GO: begin
            den_in   = product[DEN_BITS-1:0];
            state_in = ST_MEAN_WAIT;
         end
         ST_MEAN_WAIT: begin
            if (div_sts.done) begin
               mean_in  = (count_ff == '0) ? '0 : div_sts.quotient[MEAN_BITS-1:0];
               state_in = ST_VAR_GO;
            end
         end
         ST_VAR_GO: begin
            state_in = ST_VAR_WAIT;
         end
         ST_VAR_WAIT: begin
            if (div_sts.done) begin
               var_in = (count_ff < COUNT_BITS'(2) || neg_ff) ? '0
                        : div_sts.quotient[VAR_BITS-1:0];
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.count       = count_ff;
               rsp_data_in.min_value   = min_ff;
               rsp_data_in.max_value   = max_ff;
               rsp_data_in.mean_q8     = mean_ff;
               rsp_data_in.variance_q8 = var_ff;
               rsp_data_in.start_time  = start_ff;
               rsp_data_in.end_time    = end_ff;
               rsp_data_in.saturated   = sat_ff;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         min_ff       <= MIN_RESET;
         max_ff       <= '0;
         sum_ff       <= '0;
         sumsq_ff     <= '0;
         start_ff     <= '0;
         end_ff       <= '0;
         sat_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         sum_ff       <= sum_in;
         sumsq_ff     <= sumsq_in;
         start_ff     <= start_in;
         end_ff       <= end_in;
         sat_ff       <= sat_in;
      end
      smp_ff      <= smp_in;
      applied_ff  <= applied_in;
      acc_ff      <= acc_in;
      spread_ff   <= spread_in;
      neg_ff      <= neg_in;
      den_ff      <= den_in;
      mean_ff     <= mean_in;
      var_ff      <= var_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.count       = rsp_data_ff.count;
   assign rsp_port.min_value   = rsp_data_ff.min_value;
   assign rsp_port.max_value   = rsp_data_ff.max_value;
   assign rsp_port.mean_q8     = rsp_data_ff.mean_q8;
   assign rsp_port.variance_q8 = rsp_data_ff.variance_q8;
   assign rsp_port.start_time  = rsp_data_ff.start_time;
   assign rsp_port.end_time    = rsp_data_ff.end_time;
   assign rsp_port.saturated   = rsp_data_ff.saturated;

   // The divider only runs while a request is being worked on.
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !div_sts.busy)
      else $error("divider busy while the sequencer is idle");

   // A divider result is only ever produced where the sequencer waits for it.
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> (state_ff == ST_MEAN_WAIT || state_ff == ST_VAR_WAIT))
      else $error("divider finished outside a wait state");

   // A dropped sample can only have happened with a full counter.
   a_sat_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_data_ff.saturated || rsp_data_ff.count == COUNT_MAX))
      else $error("saturation reported below the maximum count");

   // An empty accumulator is exactly the one whose minimum is one above full scale.
   a_empty_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_data_ff.count == '0) == (rsp_data_ff.min_value == MIN_RESET)))
      else $error("count and minimum disagree on an empty accumulator");

endmodule
